// ===== src/uvs_pkg.sv =====
package uvs_pkg;

  localparam int unsigned MAX_SEGMENTS = 1024;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_SEGS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LON_SEGS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THETA_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THETA_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_START   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_END     = 3'd6;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] xt;
    logic signed [31:0] yt;
    logic signed [31:0] zt;
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic signed [31:0] zp;
    logic [1:0]         qt;
    logic [1:0]         qp;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } cordic_t;

  function automatic logic signed [31:0] atan_at(input int unsigned i);
    case (i)
      0:       atan_at = 32'sh20000000;
      1:       atan_at = 32'sh12E4051E;
      2:       atan_at = 32'sh09FB385B;
      3:       atan_at = 32'sh051111D4;
      4:       atan_at = 32'sh028B0D43;
      5:       atan_at = 32'sh0145D7E1;
      6:       atan_at = 32'sh00A2F61E;
      7:       atan_at = 32'sh00517C55;
      8:       atan_at = 32'sh0028BE53;
      9:       atan_at = 32'sh00145F2F;
      10:      atan_at = 32'sh000A2F98;
      11:      atan_at = 32'sh000517CC;
      12:      atan_at = 32'sh00028BE6;
      13:      atan_at = 32'sh000145F3;
      14:      atan_at = 32'sh0000A2FA;
      15:      atan_at = 32'sh0000517D;
      default: atan_at = 32'sh00000000;
    endcase
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [47:0] round_away(input logic signed [47:0] v,
                                                    input int unsigned s);
    logic signed [47:0] half;
    logic signed [47:0] m;
    half = 48'sd1 <<< (s - 1);
    m = -v;
    if (v >= 0) begin
      round_away = (v + half) >>> s;
    end else begin
      round_away = -((m + half) >>> s);
    end
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [47:0] v);
    if (v > 48'sd16384) begin
      clamp_unit = 16'sd16384;
    end else if (v < -48'sd16384) begin
      clamp_unit = -16'sd16384;
    end else begin
      clamp_unit = v[15:0];
    end
  endfunction

endpackage

// ===== src/uv_sphere_vertex_generator.sv =====
// UV-sphere vertex generator. One grid point (lat_index_i, lon_index_i) is taken
// with start in any cycle; busy stays low, so a new item can enter every cycle.
// Its vertex (normal, position, texture coordinate) appears on the outputs for one
// cycle with out_valid_o after two input stages, one restoring-divider cell per
// quotient bit (16 + $clog2(MAX_SEGMENTS+1) cells), one angle stage, sixteen
// CORDIC cells and three stages of rounding and multiplication. Results cannot be
// held off and must be taken when shown. Write configuration only while no item is
// in flight.
module uv_sphere_vertex_generator #(
  parameter int unsigned MAX_SEGMENTS = uvs_pkg::MAX_SEGMENTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [10:0]                    lat_index_i,
  input  logic [10:0]                    lon_index_i,
  output logic                           out_valid_o,
  output logic signed [15:0]             normal_x_o,
  output logic signed [15:0]             normal_y_o,
  output logic signed [15:0]             normal_z_o,
  output logic signed [16:0]             pos_x_o,
  output logic signed [16:0]             pos_y_o,
  output logic signed [16:0]             pos_z_o,
  output logic [16:0]                    tex_u_o,
  output logic [16:0]                    tex_v_o
);

  localparam int unsigned SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned NUM_W = SEG_W + 16;
  localparam int unsigned LAT   = NUM_W + 22;

  logic [15:0]        radius_q;
  logic [10:0]        lat_segs_q, lon_segs_q;
  logic signed [15:0] theta_start_q, theta_end_q, phi_start_q, phi_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= 16'd256;
      lat_segs_q    <= 11'd16;
      lon_segs_q    <= 11'd16;
      theta_start_q <= 16'sd0;
      theta_end_q   <= 16'sd32767;
      phi_start_q   <= 16'sd0;
      phi_end_q     <= 16'sd32767;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uvs_pkg::REG_RADIUS:      radius_q      <= cfg_data_i;
        uvs_pkg::REG_LAT_SEGS:    lat_segs_q    <= cfg_data_i[10:0];
        uvs_pkg::REG_LON_SEGS:    lon_segs_q    <= cfg_data_i[10:0];
        uvs_pkg::REG_THETA_START: theta_start_q <= cfg_data_i;
        uvs_pkg::REG_THETA_END:   theta_end_q   <= cfg_data_i;
        uvs_pkg::REG_PHI_START:   phi_start_q   <= cfg_data_i;
        uvs_pkg::REG_PHI_END:     phi_end_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SEG_W-1:0]   lseg, gseg;
  logic signed [16:0] th_diff, ph_diff;
  logic [16:0]        th_abs, ph_abs;

  always_comb begin
    if (lat_segs_q == 11'd0) begin
      lseg = SEG_W'(1);
    end else if (32'(lat_segs_q) > MAX_SEGMENTS) begin
      lseg = SEG_W'(MAX_SEGMENTS);
    end else begin
      lseg = SEG_W'(lat_segs_q);
    end
    if (lon_segs_q == 11'd0) begin
      gseg = SEG_W'(1);
    end else if (32'(lon_segs_q) > MAX_SEGMENTS) begin
      gseg = SEG_W'(MAX_SEGMENTS);
    end else begin
      gseg = SEG_W'(lon_segs_q);
    end
    th_diff = 17'(theta_end_q) - 17'(theta_start_q);
    ph_diff = 17'(phi_end_q) - 17'(phi_start_q);
    th_abs  = th_diff[16] ? 17'(-th_diff) : th_diff;
    ph_abs  = ph_diff[16] ? 17'(-ph_diff) : ph_diff;
  end

  // saturate indices
  logic             a_valid_q;
  logic [SEG_W-1:0] a_lat_q, a_lon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    a_lat_q <= (32'(lat_index_i) > 32'(lseg)) ? lseg : SEG_W'(lat_index_i);
    a_lon_q <= (32'(lon_index_i) > 32'(gseg)) ? gseg : SEG_W'(lon_index_i);
  end

  // divider chain, lanes: theta, phi, tex_u, tex_v
  logic                  dv_valid [NUM_W+1];
  logic [3:0][SEG_W-1:0] dv_rem   [NUM_W+1];
  logic [3:0][NUM_W-1:0] dv_nq    [NUM_W+1];
  logic [3:0][SEG_W-1:0] dv_div;
  logic [3:0][NUM_W-1:0] b_nq_d, b_nq_q;
  logic                  b_valid_q;

  assign dv_div = {lseg, gseg, gseg, lseg};

  always_comb begin
    b_nq_d[0] = NUM_W'(th_abs) * NUM_W'(a_lat_q) + NUM_W'(lseg >> 1);
    b_nq_d[1] = NUM_W'(ph_abs) * NUM_W'(a_lon_q) + NUM_W'(gseg >> 1);
    b_nq_d[2] = NUM_W'({a_lon_q, 16'h0000}) + NUM_W'(gseg >> 1);
    b_nq_d[3] = NUM_W'({a_lat_q, 16'h0000}) + NUM_W'(lseg >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_nq_q <= b_nq_d;
  end

  assign dv_valid[0] = b_valid_q;
  assign dv_rem[0]   = '0;
  assign dv_nq[0]    = b_nq_q;

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    uvs_div_cell #(
      .SEG_W (SEG_W),
      .NUM_W (NUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[i]),
      .rem_i   (dv_rem[i]),
      .nq_i    (dv_nq[i]),
      .div_i   (dv_div),
      .valid_o (dv_valid[i+1]),
      .rem_o   (dv_rem[i+1]),
      .nq_o    (dv_nq[i+1])
    );
  end

  // angles and CORDIC seed
  logic [15:0]      q_th, q_ph, theta, phi;
  uvs_pkg::cordic_t c_d, c_q;

  always_comb begin
    q_th  = dv_nq[NUM_W][0][15:0];
    q_ph  = dv_nq[NUM_W][1][15:0];
    theta = theta_start_q + (th_diff[16] ? 16'(-q_th) : q_th);
    phi   = phi_start_q + (ph_diff[16] ? 16'(-q_ph) : q_ph);
    c_d.valid = dv_valid[NUM_W];
    c_d.xt    = uvs_pkg::CORDIC_GAIN;
    c_d.yt    = 32'sd0;
    c_d.zt    = {2'b00, theta[13:0], 16'h0000};
    c_d.xp    = uvs_pkg::CORDIC_GAIN;
    c_d.yp    = 32'sd0;
    c_d.zp    = {2'b00, phi[13:0], 16'h0000};
    c_d.qt    = theta[15:14];
    c_d.qp    = phi[15:14];
    c_d.tex_u = dv_nq[NUM_W][2][16:0];
    c_d.tex_v = dv_nq[NUM_W][3][16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else begin
      c_q <= c_d;
    end
  end

  uvs_pkg::cordic_t cd [uvs_pkg::CORDIC_STEPS+1];

  assign cd[0] = c_q;

  for (genvar j = 0; j < uvs_pkg::CORDIC_STEPS; j++) begin : g_cordic
    uvs_cordic_cell #(
      .STEP (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (cd[j]),
      .q_o    (cd[j+1])
    );
  end

  // round, clamp, map quadrant
  uvs_pkg::cordic_t   cf;
  logic signed [15:0] cxt, syt, cxp, syp;
  logic signed [15:0] ct_d, st_d, cp_d, sp_d;
  logic signed [15:0] ct_q, st_q, cp_q, sp_q;
  logic               d_valid_q;
  logic [16:0]        d_u_q, d_v_q;

  always_comb begin
    cf  = cd[uvs_pkg::CORDIC_STEPS];
    cxt = uvs_pkg::clamp_unit(uvs_pkg::round_away(48'(cf.xt), 16));
    syt = uvs_pkg::clamp_unit(uvs_pkg::round_away(48'(cf.yt), 16));
    cxp = uvs_pkg::clamp_unit(uvs_pkg::round_away(48'(cf.xp), 16));
    syp = uvs_pkg::clamp_unit(uvs_pkg::round_away(48'(cf.yp), 16));
    case (cf.qt)
      2'd0:    begin ct_d = cxt;         st_d = syt;         end
      2'd1:    begin ct_d = 16'(-syt);   st_d = cxt;         end
      2'd2:    begin ct_d = 16'(-cxt);   st_d = 16'(-syt);   end
      default: begin ct_d = syt;         st_d = 16'(-cxt);   end
    endcase
    case (cf.qp)
      2'd0:    begin cp_d = cxp;         sp_d = syp;         end
      2'd1:    begin cp_d = 16'(-syp);   sp_d = cxp;         end
      2'd2:    begin cp_d = 16'(-cxp);   sp_d = 16'(-syp);   end
      default: begin cp_d = syp;         sp_d = 16'(-cxp);   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ct_q  <= ct_d;
    st_q  <= st_d;
    cp_q  <= cp_d;
    sp_q  <= sp_d;
    d_u_q <= cf.tex_u;
    d_v_q <= cf.tex_v;
  end

  // normals
  logic               e_valid_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic [16:0]        e_u_q, e_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= uvs_pkg::clamp_unit(uvs_pkg::round_away(48'(st_q) * 48'(cp_q), 14));
    ny_q  <= ct_q;
    nz_q  <= uvs_pkg::clamp_unit(uvs_pkg::round_away(48'(st_q) * 48'(sp_q), 14));
    e_u_q <= d_u_q;
    e_v_q <= d_v_q;
  end

  // positions and output register
  logic signed [16:0] rad_s;
  logic               f_valid_q;
  logic signed [15:0] f_nx_q, f_ny_q, f_nz_q;
  logic signed [16:0] px_q, py_q, pz_q;
  logic [16:0]        f_u_q, f_v_q;
  logic signed [47:0] px_r, py_r, pz_r;

  always_comb begin
    rad_s = $signed({1'b0, radius_q});
    px_r  = uvs_pkg::round_away(48'(rad_s) * 48'(nx_q), 14);
    py_r  = uvs_pkg::round_away(48'(rad_s) * 48'(ny_q), 14);
    pz_r  = uvs_pkg::round_away(48'(rad_s) * 48'(nz_q), 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_nx_q <= nx_q;
    f_ny_q <= ny_q;
    f_nz_q <= nz_q;
    px_q   <= px_r[16:0];
    py_q   <= py_r[16:0];
    pz_q   <= pz_r[16:0];
    f_u_q  <= e_u_q;
    f_v_q  <= e_v_q;
  end

  assign busy        = 1'b0;
  assign out_valid_o = f_valid_q;
  assign normal_x_o  = f_nx_q;
  assign normal_y_o  = f_ny_q;
  assign normal_z_o  = f_nz_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign pos_z_o     = pz_q;
  assign tex_u_o     = f_u_q;
  assign tex_v_o     = f_v_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT out_valid_o)
    else $error("item did not come out after fixed latency");

  a_normal_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
                     normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384 &&
                     normal_z_o <= 16'sd16384 && normal_z_o >= -16'sd16384))
    else $error("normal out of unit range");

  a_tex_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'd65536 && tex_v_o <= 17'd65536))
    else $error("texture coordinate above one");

endmodule

// ===== src/uvs_div_cell.sv =====
module uvs_div_cell #(
  parameter int unsigned SEG_W = 11,
  parameter int unsigned NUM_W = 27
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [3:0][SEG_W-1:0]      rem_i,
  input  logic [3:0][NUM_W-1:0]      nq_i,
  input  logic [3:0][SEG_W-1:0]      div_i,
  output logic                       valid_o,
  output logic [3:0][SEG_W-1:0]      rem_o,
  output logic [3:0][NUM_W-1:0]      nq_o
);

  logic                  valid_q;
  logic [3:0][SEG_W-1:0] rem_d, rem_q;
  logic [3:0][NUM_W-1:0] nq_d, nq_q;
  logic [3:0][SEG_W:0]   trial;
  logic [3:0][SEG_W:0]   diff;
  logic [3:0]            ge;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial[l] = {rem_i[l], nq_i[l][NUM_W-1]};
      diff[l]  = trial[l] - {1'b0, div_i[l]};
      ge[l]    = trial[l] >= {1'b0, div_i[l]};
      rem_d[l] = ge[l] ? diff[l][SEG_W-1:0] : trial[l][SEG_W-1:0];
      nq_d[l]  = {nq_i[l][NUM_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;

endmodule

// ===== src/uvs_cordic_cell.sv =====
module uvs_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uvs_pkg::cordic_t d_i,
  output uvs_pkg::cordic_t q_o
);

  localparam logic signed [31:0] Atan = uvs_pkg::atan_at(STEP);

  uvs_pkg::cordic_t   stage_d, stage_q;
  logic signed [31:0] xs_t, ys_t, xs_p, ys_p;

  always_comb begin
    xs_t    = d_i.xt >>> STEP;
    ys_t    = d_i.yt >>> STEP;
    xs_p    = d_i.xp >>> STEP;
    ys_p    = d_i.yp >>> STEP;
    stage_d = d_i;
    if (d_i.zt >= 0) begin
      stage_d.xt = d_i.xt - ys_t;
      stage_d.yt = d_i.yt + xs_t;
      stage_d.zt = d_i.zt - Atan;
    end else begin
      stage_d.xt = d_i.xt + ys_t;
      stage_d.yt = d_i.yt - xs_t;
      stage_d.zt = d_i.zt + Atan;
    end
    if (d_i.zp >= 0) begin
      stage_d.xp = d_i.xp - ys_p;
      stage_d.yp = d_i.yp + xs_p;
      stage_d.zp = d_i.zp - Atan;
    end else begin
      stage_d.xp = d_i.xp + ys_p;
      stage_d.yp = d_i.yp - xs_p;
      stage_d.zp = d_i.zp + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign q_o = stage_q;

endmodule
